// ----- hdl/pbs_pkg.sv -----
// Package for the projectile bounce step block: types, constants, helpers.
// Used by pbs_ctrl, pbs_dp and projectile_bounce_step. No dependencies.
`default_nettype none
package pbs_pkg;

  localparam int TRAIL_DEPTH = 2048;
  localparam int PH_W = $clog2(TRAIL_DEPTH + 1);
  localparam int ADDR_W = 5;

  localparam logic [ADDR_W-1:0] REG_GRAVITY  = 5'd0;
  localparam logic [ADDR_W-1:0] REG_GROUND   = 5'd4;
  localparam logic [ADDR_W-1:0] REG_RESTIT   = 5'd8;
  localparam logic [ADDR_W-1:0] REG_DAMPING  = 5'd12;
  localparam logic [ADDR_W-1:0] REG_REST_SPD = 5'd16;
  localparam logic [ADDR_W-1:0] REG_SPACING  = 5'd20;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LAUNCH, ST_FALL, ST_VY, ST_PX, ST_PY, ST_PZ, ST_GND,
    ST_BVY, ST_BVX, ST_BVZ, ST_SQY, ST_SQX, ST_SQZ, ST_STOP,
    ST_DX, ST_DY, ST_DZ, ST_TRAIL, ST_OUT
  } pbs_state_t;

  // Multiplier operand selection
  typedef enum logic [3:0] {
    MS_FALL, MS_PX, MS_PY, MS_PZ, MS_BVY, MS_BVX, MS_BVZ,
    MS_SQY, MS_SQX, MS_SQZ, MS_SQR, MS_DX, MS_DY, MS_DZ, MS_SQS
  } pbs_msel_t;

  typedef struct packed {
    pbs_state_t st;
  } pbs_cmd_t;

  typedef struct packed {
    logic is_launch;
    logic below;
  } pbs_stat_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'(Q_MAX)) r = Q_MAX;
    else if (x < 34'(Q_MIN)) r = Q_MIN;
    else r = x[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pbs_ctrl.sv -----
// Controller state machine for the projectile bounce step.
// Depends on pbs_pkg; steps the datapath one operation per state.
`default_nettype none
module pbs_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  input  wire              out_taken,
  input  pbs_pkg::pbs_stat_t stat,
  output pbs_pkg::pbs_cmd_t  cmd,
  output logic             busy
);

  pbs_pkg::pbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pbs_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // Sequence: gravity, positions, ground test, bounce, trail test.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbs_pkg::ST_IDLE: begin
        if (start) state_nxt = stat.is_launch ? pbs_pkg::ST_LAUNCH : pbs_pkg::ST_FALL;
      end
      pbs_pkg::ST_LAUNCH: state_nxt = pbs_pkg::ST_OUT;
      pbs_pkg::ST_FALL:   state_nxt = pbs_pkg::ST_VY;
      pbs_pkg::ST_VY:     state_nxt = pbs_pkg::ST_PX;
      pbs_pkg::ST_PX:     state_nxt = pbs_pkg::ST_PY;
      pbs_pkg::ST_PY:     state_nxt = pbs_pkg::ST_PZ;
      pbs_pkg::ST_PZ:     state_nxt = pbs_pkg::ST_GND;
      pbs_pkg::ST_GND:    state_nxt = stat.below ? pbs_pkg::ST_BVY : pbs_pkg::ST_DX;
      pbs_pkg::ST_BVY:    state_nxt = pbs_pkg::ST_BVX;
      pbs_pkg::ST_BVX:    state_nxt = pbs_pkg::ST_BVZ;
      pbs_pkg::ST_BVZ:    state_nxt = pbs_pkg::ST_SQY;
      pbs_pkg::ST_SQY:    state_nxt = pbs_pkg::ST_SQX;
      pbs_pkg::ST_SQX:    state_nxt = pbs_pkg::ST_SQZ;
      pbs_pkg::ST_SQZ:    state_nxt = pbs_pkg::ST_STOP;
      pbs_pkg::ST_STOP:   state_nxt = pbs_pkg::ST_DX;
      pbs_pkg::ST_DX:     state_nxt = pbs_pkg::ST_DY;
      pbs_pkg::ST_DY:     state_nxt = pbs_pkg::ST_DZ;
      pbs_pkg::ST_DZ:     state_nxt = pbs_pkg::ST_TRAIL;
      pbs_pkg::ST_TRAIL:  state_nxt = pbs_pkg::ST_OUT;
      pbs_pkg::ST_OUT: begin
        if (out_taken) state_nxt = pbs_pkg::ST_IDLE;
      end
      default: state_nxt = pbs_pkg::ST_IDLE;
    endcase
  end

  assign cmd.st = state_r;
  assign busy   = (state_r != pbs_pkg::ST_IDLE);

endmodule
`default_nettype wire

// ----- hdl/pbs_dp.sv -----
// Datapath: state registers, one shared 34x34 signed multiplier, squares.
// Depends on pbs_pkg; driven by pbs_ctrl commands.
`default_nettype none
module pbs_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  load,
  input  wire                  in_cmd,
  input  wire [15:0]           in_time_step,
  input  wire signed [31:0]    in_launch_vx,
  input  wire signed [31:0]    in_launch_vy,
  input  wire signed [31:0]    in_launch_vz,
  input  wire [30:0]           gravity,
  input  wire signed [31:0]    ground,
  input  wire [15:0]           restit,
  input  wire [15:0]           damping,
  input  wire [30:0]           rest_spd,
  input  wire [30:0]           spacing,
  input  pbs_pkg::pbs_cmd_t    cmd,
  output pbs_pkg::pbs_stat_t   stat,
  output logic signed [31:0]   pos_x,
  output logic signed [31:0]   pos_y,
  output logic signed [31:0]   pos_z,
  output logic                 trail_add,
  output logic [11:0]          trail_count,
  output logic                 on_ground
);

  logic signed [31:0] px_r, py_r, pz_r, vx_r, vy_r, vz_r, lx_r, ly_r, lz_r;
  logic [pbs_pkg::PH_W-1:0] ph_r;
  logic [15:0] dt_r;
  logic add_r, gnd_r;
  logic signed [67:0] prod_r;
  logic [63:0] sq_a_r, sq_r2_r, sq_d_r;
  logic far_r;

  // Shared multiplier operands
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [33:0] fl;
  logic signed [32:0] d;
  logic [32:0] ad;
  logic [32:0] avy;

  assign avy = vy_r[31] ? 33'(-34'(vy_r)) : 33'(vy_r);

  always_comb begin
    ma = '0;
    mb = '0;
    d  = '0;
    unique case (cmd.st)
      pbs_pkg::ST_FALL: begin ma = 34'(gravity); mb = 34'(dt_r); end
      pbs_pkg::ST_PX:   begin ma = 34'(vx_r); mb = 34'(dt_r); end
      pbs_pkg::ST_PY:   begin ma = 34'(vy_r); mb = 34'(dt_r); end
      pbs_pkg::ST_PZ:   begin ma = 34'(vz_r); mb = 34'(dt_r); end
      pbs_pkg::ST_BVY:  begin ma = 34'(avy); mb = 34'(restit); end
      pbs_pkg::ST_BVX:  begin ma = 34'(vx_r); mb = 34'(damping); end
      pbs_pkg::ST_BVZ:  begin ma = 34'(vz_r); mb = 34'(damping); end
      pbs_pkg::ST_SQY:  begin ma = 34'(vy_r); mb = 34'(vy_r); end
      pbs_pkg::ST_SQX:  begin ma = 34'(vx_r); mb = 34'(vx_r); end
      pbs_pkg::ST_SQZ:  begin ma = 34'(vz_r); mb = 34'(vz_r); end
      pbs_pkg::ST_STOP: begin ma = 34'(rest_spd); mb = 34'(rest_spd); end
      pbs_pkg::ST_DX:   d = 33'(px_r) - 33'(lx_r);
      pbs_pkg::ST_DY:   d = 33'(py_r) - 33'(ly_r);
      pbs_pkg::ST_DZ:   d = 33'(pz_r) - 33'(lz_r);
      pbs_pkg::ST_TRAIL: begin ma = 34'(spacing); mb = 34'(spacing); end
      default: ;
    endcase
    ad = d[32] ? 33'(-d) : 33'(d);
    if (cmd.st == pbs_pkg::ST_DX || cmd.st == pbs_pkg::ST_DY
        || cmd.st == pbs_pkg::ST_DZ) begin
      ma = 34'(ad);
      mb = 34'(ad);
    end
  end

  assign prod = ma * mb;
  assign fl   = 34'(prod_r >>> 16);

  assign stat.is_launch = in_cmd;
  assign stat.below     = (py_r < ground);

  // Registered operations, one per controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; pz_r <= '0;
      vx_r <= '0; vy_r <= 32'sd655360; vz_r <= -32'sd393216;
      lx_r <= '0; ly_r <= '0; lz_r <= '0;
      ph_r <= pbs_pkg::PH_W'(1);
      add_r <= 1'b0; gnd_r <= 1'b0;
    end else begin
      prod_r <= prod;
      if (load) begin
        dt_r  <= in_time_step;
        add_r <= 1'b0;
        gnd_r <= 1'b0;
        far_r <= 1'b0;
        sq_d_r <= '0;
        // Launch vector is taken with the item itself
        if (in_cmd) begin
          vx_r <= in_launch_vx; vy_r <= in_launch_vy; vz_r <= in_launch_vz;
        end
      end
      unique case (cmd.st)
        pbs_pkg::ST_LAUNCH: begin
          px_r <= '0; py_r <= ground; pz_r <= '0;
          lx_r <= '0; ly_r <= ground; lz_r <= '0;
          ph_r <= pbs_pkg::PH_W'(1);
          add_r <= 1'b1;
        end
        pbs_pkg::ST_VY: vy_r <= pbs_pkg::sat32(34'(vy_r) - fl);
        pbs_pkg::ST_PY: px_r <= pbs_pkg::sat32(34'(px_r) + fl);
        pbs_pkg::ST_PZ: py_r <= pbs_pkg::sat32(34'(py_r) + fl);
        pbs_pkg::ST_GND: begin
          pz_r <= pbs_pkg::sat32(34'(pz_r) + fl);
        end
        pbs_pkg::ST_BVY: begin
          gnd_r <= 1'b1;
          py_r  <= ground;
        end
        pbs_pkg::ST_BVX: vy_r <= pbs_pkg::sat32(fl);
        pbs_pkg::ST_BVZ: vx_r <= fl[31:0];
        pbs_pkg::ST_SQY: vz_r <= fl[31:0];
        pbs_pkg::ST_SQX: sq_a_r <= 64'(prod_r);
        pbs_pkg::ST_SQZ: sq_r2_r <= 64'(prod_r);
        pbs_pkg::ST_STOP: sq_r2_r <= sq_r2_r + 64'(prod_r);
        pbs_pkg::ST_DX: begin
          if (sq_a_r < 64'(prod_r) && sq_r2_r < 64'(prod_r)) begin
            vx_r <= '0; vy_r <= '0; vz_r <= '0;
          end
        end
        default: ;
      endcase
      // Any axis past the spacing makes the point far
      if ((cmd.st == pbs_pkg::ST_DX || cmd.st == pbs_pkg::ST_DY
          || cmd.st == pbs_pkg::ST_DZ) && ad > 33'(spacing))
        far_r <= 1'b1;
      // Distance accumulate, one axis per cycle after its square lands
      if (cmd.st == pbs_pkg::ST_DY || cmd.st == pbs_pkg::ST_DZ
          || cmd.st == pbs_pkg::ST_TRAIL) begin
        sq_d_r <= sq_d_r + 64'(prod_r);
      end
      if (cmd.st == pbs_pkg::ST_TRAIL) begin
        if (far_r || sq_d_r + 64'(prod_r) > 64'(prod)) begin
          add_r <= 1'b1;
          lx_r <= px_r; ly_r <= py_r; lz_r <= pz_r;
          if (ph_r < pbs_pkg::PH_W'(pbs_pkg::TRAIL_DEPTH)) ph_r <= ph_r + 1'b1;
        end
      end
    end
  end

  assign pos_x       = px_r;
  assign pos_y       = py_r;
  assign pos_z       = pz_r;
  assign trail_add   = add_r;
  assign trail_count = 12'(ph_r);
  assign on_ground   = gnd_r;

endmodule
`default_nettype wire

// ----- hdl/projectile_bounce_step.sv -----
// Top level of the projectile bounce step: APB registers, controller, datapath.
// Depends on pbs_pkg, pbs_ctrl and pbs_dp.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_cmd, in_time_step, in_launch_v*
//  out     | output    | out_valid, out_stall, out_pos_*, out_trail_*, out_on_ground
//  cfg     | APB slave | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata
//
// A tick result is valid once the controller has run its states, more with a
// bounce, a launch after ST_LAUNCH alone; one shared multiplier sets the length.
// One item is in work at a time; in_stall is high until its result is taken.
// Reset restores register defaults and the power-on ball state.
// The result holds on the out ports while out_stall is high.
`default_nettype none
module projectile_bounce_step (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire               in_cmd,
  input  wire [15:0]        in_time_step,
  input  wire signed [31:0] in_launch_vx,
  input  wire signed [31:0] in_launch_vy,
  input  wire signed [31:0] in_launch_vz,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic              out_trail_add,
  output logic [11:0]       out_trail_count,
  output logic              out_on_ground,
  input  wire               cfg_psel,
  input  wire               cfg_penable,
  input  wire               cfg_pwrite,
  input  wire [4:0]         cfg_paddr,
  input  wire [31:0]        cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [30:0] grav_r, rest_r, spc_r;
  logic signed [31:0] gnd_r;
  logic [15:0] resti_r, damp_r;
  logic busy, start;
  pbs_pkg::pbs_cmd_t  cmd;
  pbs_pkg::pbs_stat_t stat;

  assign cfg_pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= 31'd642908; gnd_r <= 32'sd6554; resti_r <= 16'd22938;
      damp_r <= 16'd58982; rest_r <= 31'd13107; spc_r <= 31'd1966;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr)
        pbs_pkg::REG_GRAVITY:  grav_r  <= cfg_pwdata[30:0];
        pbs_pkg::REG_GROUND:   gnd_r   <= cfg_pwdata;
        pbs_pkg::REG_RESTIT:   resti_r <= cfg_pwdata[15:0];
        pbs_pkg::REG_DAMPING:  damp_r  <= cfg_pwdata[15:0];
        pbs_pkg::REG_REST_SPD: rest_r  <= cfg_pwdata[30:0];
        pbs_pkg::REG_SPACING:  spc_r   <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_paddr)
      pbs_pkg::REG_GRAVITY:  cfg_prdata = {1'b0, grav_r};
      pbs_pkg::REG_GROUND:   cfg_prdata = gnd_r;
      pbs_pkg::REG_RESTIT:   cfg_prdata = {16'd0, resti_r};
      pbs_pkg::REG_DAMPING:  cfg_prdata = {16'd0, damp_r};
      pbs_pkg::REG_REST_SPD: cfg_prdata = {1'b0, rest_r};
      pbs_pkg::REG_SPACING:  cfg_prdata = {1'b0, spc_r};
      default:               cfg_prdata = '0;
    endcase
  end

  assign in_stall  = busy;
  assign start     = in_valid && !busy;
  assign out_valid = (cmd.st == pbs_pkg::ST_OUT);

  pbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_taken(!out_stall),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  pbs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .load(start), .in_cmd(in_cmd),
    .in_time_step(in_time_step), .in_launch_vx(in_launch_vx),
    .in_launch_vy(in_launch_vy), .in_launch_vz(in_launch_vz),
    .gravity(grav_r), .ground(gnd_r), .restit(resti_r), .damping(damp_r),
    .rest_spd(rest_r), .spacing(spc_r), .cmd(cmd), .stat(stat),
    .pos_x(out_pos_x), .pos_y(out_pos_y), .pos_z(out_pos_z),
    .trail_add(out_trail_add), .trail_count(out_trail_count),
    .on_ground(out_on_ground)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for projectile_bounce_step: random and directed ticks and launches
// checked against a bit-exact predictor. Depends on pbs_pkg and the RTL top.
`timescale 1ns / 100ps
module tb;

  typedef struct {
    logic        cmd;
    logic [15:0] dt;
    logic [31:0] vx, vy, vz;
  } tick_item_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic        add;
    logic [11:0] cnt;
    logic        gnd;
  } ball_pos_t;

  localparam int WDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_stall, in_cmd;
  logic [15:0] in_time_step;
  logic [31:0] in_launch_vx, in_launch_vy, in_launch_vz;
  logic out_valid, out_stall;
  logic [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_trail_add, out_on_ground;
  logic [11:0] out_trail_count;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  projectile_bounce_step u_dut (.*);

  // Ball model state and register copies
  longint grav, ground, restit, damp, rest_spd, spacing;
  longint pos[3], vel[3], last_pt[3];
  int unsigned held;

  tick_item_t pending[$];
  ball_pos_t  expected_pos[$];
  int errors, shown;
  bit no_idle, hold_req;
  int idle_wait;

  function automatic longint sat(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint unsigned sqr(input longint v);
    longint unsigned a;
    a = (v < 0) ? -v : v;
    return a * a;
  endfunction

  // Append one item to the driver queue
  function automatic void queue_item(input tick_item_t it);
    pending = {pending, it};
  endfunction

  // Advance the ball model by one item and queue the position it yields
  task automatic step_ball(input tick_item_t it);
    ball_pos_t r;
    longint dt, avy, d;
    longint unsigned a, sum, r2;
    bit far;
    r.add = 0;
    r.gnd = 0;
    if (it.cmd) begin
      pos[0] = 0; pos[1] = ground; pos[2] = 0;
      vel[0] = longint'($signed(it.vx));
      vel[1] = longint'($signed(it.vy));
      vel[2] = longint'($signed(it.vz));
      for (int i = 0; i < 3; i++) last_pt[i] = pos[i];
      held = 1;
      r.add = 1;
    end else begin
      dt = longint'(it.dt);
      vel[1] = sat(vel[1] - ((grav * dt) >>> 16));
      for (int i = 0; i < 3; i++) pos[i] = sat(pos[i] + ((vel[i] * dt) >>> 16));
      if (pos[1] < ground) begin
        avy = (vel[1] < 0) ? -vel[1] : vel[1];
        r2 = longint'(rest_spd) * longint'(rest_spd);
        r.gnd = 1;
        pos[1] = ground;
        vel[1] = sat((avy * restit) >>> 16);
        vel[0] = (vel[0] * damp) >>> 16;
        vel[2] = (vel[2] * damp) >>> 16;
        if (sqr(vel[1]) < r2 && sqr(vel[0]) + sqr(vel[2]) < r2) begin
          vel[0] = 0; vel[1] = 0; vel[2] = 0;
        end
      end
      far = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        d = pos[i] - last_pt[i];
        a = (d < 0) ? -d : d;
        if (a > longint'(spacing)) far = 1;
        else sum += a * a;
      end
      if (far || sum > longint'(spacing) * longint'(spacing)) begin
        r.add = 1;
        for (int i = 0; i < 3; i++) last_pt[i] = pos[i];
        if (held < pbs_pkg::TRAIL_DEPTH) held++;
      end
    end
    r.px = pos[0][31:0];
    r.py = pos[1][31:0];
    r.pz = pos[2][31:0];
    r.cnt = held[11:0];
    expected_pos = {expected_pos, r};
  endtask

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Driver: offers queued items, idles at random
  always @(posedge clk) begin
    bit taken, next_v;
    tick_item_t it;
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        it.cmd = in_cmd; it.dt = in_time_step;
        it.vx = in_launch_vx; it.vy = in_launch_vy; it.vz = in_launch_vz;
        step_ball(it);
      end
      next_v = in_valid && !taken;
      if (!next_v && pending.size() > 0 && (no_idle || $urandom_range(0, 99) >= 15)) begin
        it = pending.pop_front();
        in_cmd <= it.cmd; in_time_step <= it.dt;
        in_launch_vx <= it.vx; in_launch_vy <= it.vy; in_launch_vz <= it.vz;
        next_v = 1;
      end
      in_valid <= next_v;
    end
  end

  // Monitor: random stall, one long hold-off, compare results
  always @(posedge clk) begin
    ball_pos_t e;
    if (!rst_n) begin
      out_stall <= 0;
      idle_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pos.size() == 0) begin
          errors++;
          if (shown < 10) begin
            shown++;
            $display("tb: result with nothing expected: pos %h %h %h", out_pos_x,
                     out_pos_y, out_pos_z);
          end
        end else begin
          e = expected_pos.pop_front();
          if (e.px !== out_pos_x || e.py !== out_pos_y || e.pz !== out_pos_z ||
              e.add !== out_trail_add || e.cnt !== out_trail_count ||
              e.gnd !== out_on_ground) begin
            errors++;
            if (shown < 10) begin
              shown++;
              $display("tb: mismatch exp pos %h %h %h add %b cnt %0d gnd %b", e.px, e.py,
                       e.pz, e.add, e.cnt, e.gnd);
              $display("tb:          got pos %h %h %h add %b cnt %0d gnd %b", out_pos_x,
                       out_pos_y, out_pos_z, out_trail_add, out_trail_count, out_on_ground);
            end
          end
        end
      end
      if (hold_req && idle_wait == 0) begin
        idle_wait <= 400;
        out_stall <= 1;
      end else if (idle_wait > 1) begin
        idle_wait <= idle_wait - 1;
        out_stall <= 1;
      end else begin
        if (idle_wait == 1) idle_wait <= -1;
        out_stall <= !no_idle && ($urandom_range(0, 99) < 15);
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [4:0] addr, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= addr; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (addr)
      pbs_pkg::REG_GRAVITY:  grav = longint'(val[30:0]);
      pbs_pkg::REG_GROUND:   ground = longint'($signed(val));
      pbs_pkg::REG_RESTIT:   restit = longint'(val[15:0]);
      pbs_pkg::REG_DAMPING:  damp = longint'(val[15:0]);
      pbs_pkg::REG_REST_SPD: rest_spd = longint'(val[30:0]);
      pbs_pkg::REG_SPACING:  spacing = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] g, gl, rs, dm, rsp, sp);
    reg_write(pbs_pkg::REG_GRAVITY, g);
    reg_write(pbs_pkg::REG_GROUND, gl);
    reg_write(pbs_pkg::REG_RESTIT, rs);
    reg_write(pbs_pkg::REG_DAMPING, dm);
    reg_write(pbs_pkg::REG_REST_SPD, rsp);
    reg_write(pbs_pkg::REG_SPACING, sp);
  endtask

  function automatic tick_item_t mk(input logic cmd, input logic [15:0] dt,
                                    input logic [31:0] vx, vy, vz);
    tick_item_t it;
    it.cmd = cmd; it.dt = dt; it.vx = vx; it.vy = vy; it.vz = vz;
    return it;
  endfunction

  // Random flights: launch then a run of ticks, some noise and wild values
  task automatic add_flights(input int n);
    int cnt, ticks;
    logic [31:0] vx, vy, vz;
    logic [15:0] dt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 2) begin
        vx = $urandom; vy = $urandom; vz = $urandom;
      end else begin
        vx = $urandom_range(0, 20 << 16) - (10 << 16);
        vy = $urandom_range(0, 30 << 16);
        vz = $urandom_range(0, 20 << 16) - (10 << 16);
      end
      queue_item(mk(1, 16'($urandom), vx, vy, vz));
      cnt++;
      ticks = $urandom_range(5, 40);
      for (int i = 0; i < ticks && cnt < n; i++) begin
        case ($urandom_range(0, 9))
          0: dt = 16'($urandom);
          1: dt = 16'($urandom_range(0, 3));
          default: dt = 16'($urandom_range(500, 12000));
        endcase
        queue_item(mk(0, dt, $urandom, $urandom, $urandom));
        cnt++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || expected_pos.size() != 0 || in_valid)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0; in_cmd = 0; in_time_step = 0;
    in_launch_vx = 0; in_launch_vy = 0; in_launch_vz = 0;
    out_stall = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    errors = 0; shown = 0; no_idle = 0; hold_req = 0;
    grav = 642908; ground = 6554; restit = 22938; damp = 58982;
    rest_spd = 13107; spacing = 1966;
    pos = '{0, 0, 0}; vel = '{0, 655360, -393216}; last_pt = '{0, 0, 0};
    held = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1;

    // Directed: power-on ball, extreme steps and launch vectors
    queue_item(mk(0, 16'h0000, 0, 0, 0));
    queue_item(mk(0, 16'hFFFF, 0, 0, 0));
    queue_item(mk(0, 16'h0400, 0, 0, 0));
    queue_item(mk(1, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    queue_item(mk(0, 16'hFFFF, 0, 0, 0));
    queue_item(mk(0, 16'hFFFF, 0, 0, 0));
    queue_item(mk(1, 16'h0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    queue_item(mk(0, 16'hFFFF, 0, 0, 0));
    queue_item(mk(0, 16'h8000, 0, 0, 0));
    queue_item(mk(1, 16'h1234, 0, 32'h0000_8000, 0));
    for (int i = 0; i < 8; i++) queue_item(mk(0, 16'h4000, 0, 0, 0));
    queue_item(mk(1, 0, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000));
    for (int i = 0; i < 4; i++) queue_item(mk(0, 16'h8000, 0, 0, 0));
    wait_idle();

    // Reset-value registers
    hold_req <= 1;
    add_flights(120);
    @(posedge clk);
    hold_req <= 0;
    wait_idle();

    set_regs(0, 32'h8000_0000, 0, 0, 0, 0);
    add_flights(100);
    wait_idle();

    no_idle <= 1;
    set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF);
    add_flights(100);
    wait_idle();
    no_idle <= 0;

    set_regs(642908, 0, 40000, 50000, 1 << 16, 1 << 14);
    add_flights(150);
    wait_idle();

    set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    add_flights(100);
    wait_idle();

    set_regs($urandom_range(1 << 16, 40 << 16), $urandom_range(0, 1 << 18) - (1 << 17),
             $urandom, $urandom, $urandom_range(0, 4 << 16), $urandom_range(0, 1 << 15));
    add_flights(160);
    wait_idle();

    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
